// ----- rtl/core/fpgs_pkg.sv -----
// Shared types, codes and reset values of the fuel pump gate safety sequencer.
package fpgs_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned QDepth  = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PRIME_TIME = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALL_TIME = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RPM_THR    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COIL_ON    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COIL_OFF   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HEARTBEAT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COIL_GAIN  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_IDX  = 3'd7;

  // Configuration reset values.
  localparam logic [15:0] PRIME_TIME_RST = 16'd3000;
  localparam logic [15:0] STALL_TIME_RST = 16'd2000;
  localparam logic [15:0] RPM_THR_RST    = 16'd200;
  localparam logic [11:0] COIL_ON_RST    = 12'd600;
  localparam logic [11:0] COIL_OFF_RST   = 12'd400;
  localparam logic [15:0] HEARTBEAT_RST  = 16'd1000;
  localparam logic [15:0] COIL_GAIN_RST  = 16'd29285;
  localparam logic [2:0]  RELAY_IDX_RST  = 3'd0;

  localparam logic [2:0]  GATE_MODE_RST  = 3'd3;
  localparam logic [2:0]  GATE_MODE_OFF  = 3'd0;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_RPM       = 2'd1,
    KIND_COIL      = 2'd2,
    KIND_GATE_MODE = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    RES_RELAY     = 2'd0,
    RES_STATE     = 2'd1,
    RES_STALL     = 2'd2,
    RES_IGNITION  = 2'd3
  } res_kind_e;

  typedef enum logic [1:0] {
    PS_PRIME   = 2'd0,
    PS_ARMED   = 2'd1,
    PS_RUNNING = 2'd2
  } pump_state_e;

  typedef enum logic [1:0] {
    RSN_PRIME_DONE = 2'd0,
    RSN_GATES_PASS = 2'd1,
    RSN_STALL      = 2'd2,
    RSN_MODE       = 2'd3
  } reason_e;

  // What one item leaves for the back end to expand into beats.
  typedef enum logic [1:0] {
    REC_ANNOUNCE = 2'd0,
    REC_STALL    = 2'd1,
    REC_IGNITION = 2'd2
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e          rtype;
    logic [7:0]         relay_mask;
    logic               relay_on;
    logic [1:0]         pump_state;
    logic [2:0]         gate_mode;
    reason_e            reason;
    logic [1:0]         gates_ok;
    logic [LevelW-1:0]  coil_level;
    logic               coil_is_on;
  } rec_t;

endpackage

// ----- rtl/core/fpgs_front.sv -----
// Front end: accepts items, holds configuration and sequencer state, emits records.
module fpgs_front import fpgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode_i,
  input  logic [TimeW-1:0]    time_ms_i,
  input  logic [15:0]         rpm_i,
  input  logic [LevelW-1:0]   coil_raw_i,
  input  logic [7:0]          new_gate_mode_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                q_full_i,
  output logic                q_wr_o,
  output rec_t                q_rec_o
);

  // Configuration registers.
  logic [15:0]       prime_time_q, stall_time_q, rpm_thr_q, heartbeat_q, coil_gain_q;
  logic [LevelW-1:0] coil_on_lvl_q, coil_off_q;
  logic [2:0]        relay_idx_q;

  // Accepted item, with the coil level already scaled.
  logic              a_valid_q, a_valid_d;
  item_kind_e        a_kind_q;
  logic [TimeW-1:0]  a_time_q;
  logic [15:0]       a_rpm_q;
  logic [LevelW-1:0] a_cv_q;
  logic [2:0]        a_gm_q;

  // Sequencer state.
  pump_state_e       ps_q, ps_d;
  logic [TimeW-1:0]  entry_q, entry_d;
  logic [2:0]        gm_q, gm_d;
  logic [TimeW-1:0]  rpm_good_q, rpm_good_d, coil_good_q, coil_good_d;
  logic [TimeW-1:0]  last_rep_q, last_rep_d;
  logic              rpm_seen_q, rpm_seen_d, coil_seen_q, coil_seen_d;
  logic              coil_on_q, coil_on_d;

  logic              accept, process;
  logic [27:0]       coil_prod;
  logic [TimeW-1:0]  dt_entry, dt_rpm, dt_coil, dt_rep;
  logic              rpm_fresh, coil_fresh, gates_pass, prime_done;
  logic              move, ign;
  reason_e           reason;

  assign full    = a_valid_q && q_full_i;
  assign accept  = push && !full;
  assign process = a_valid_q && !q_full_i;

  assign coil_prod = {16'd0, coil_raw_i} * {12'd0, coil_gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_time_q  <= PRIME_TIME_RST;
      stall_time_q  <= STALL_TIME_RST;
      rpm_thr_q     <= RPM_THR_RST;
      coil_on_lvl_q <= COIL_ON_RST;
      coil_off_q    <= COIL_OFF_RST;
      heartbeat_q   <= HEARTBEAT_RST;
      coil_gain_q   <= COIL_GAIN_RST;
      relay_idx_q   <= RELAY_IDX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRIME_TIME: prime_time_q  <= cfg_data_i;
        CFG_STALL_TIME: stall_time_q  <= cfg_data_i;
        CFG_RPM_THR:    rpm_thr_q     <= cfg_data_i;
        CFG_COIL_ON:    coil_on_lvl_q <= cfg_data_i[LevelW-1:0];
        CFG_COIL_OFF:   coil_off_q    <= cfg_data_i[LevelW-1:0];
        CFG_HEARTBEAT:  heartbeat_q   <= cfg_data_i;
        CFG_COIL_GAIN:  coil_gain_q   <= cfg_data_i;
        CFG_RELAY_IDX:  relay_idx_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (process) a_valid_d = 1'b0;
    if (accept)  a_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_kind_q <= item_kind_e'(mode_i);
      a_time_q <= time_ms_i;
      a_rpm_q  <= rpm_i;
      a_cv_q   <= coil_prod[27:16];
      a_gm_q   <= new_gate_mode_i[2:0];
    end
  end

  // Freshness is judged on wrapping differences against the current stamp.
  assign dt_entry   = a_time_q - entry_q;
  assign dt_rpm     = a_time_q - rpm_good_q;
  assign dt_coil    = a_time_q - coil_good_q;
  assign dt_rep     = a_time_q - last_rep_q;
  assign rpm_fresh  = rpm_seen_q && (dt_rpm < {16'd0, stall_time_q});
  assign coil_fresh = coil_seen_q && (dt_coil < {16'd0, stall_time_q});
  assign gates_pass = (!gm_q[0] || rpm_fresh) && (!gm_q[1] || coil_fresh);
  assign prime_done = dt_entry >= {16'd0, prime_time_q};

  // Sequencer next state.
  always_comb begin
    ps_d    = ps_q;
    entry_d = entry_q;
    gm_d    = gm_q;
    move    = 1'b0;
    reason  = RSN_PRIME_DONE;
    if (process) begin
      case (a_kind_q)
        KIND_TICK: begin
          if (gm_q != GATE_MODE_OFF) begin
            case (ps_q)
              PS_PRIME: begin
                if (prime_done) begin
                  ps_d   = PS_ARMED;
                  move   = 1'b1;
                  reason = RSN_PRIME_DONE;
                end
              end
              PS_ARMED: begin
                if (gates_pass) begin
                  ps_d   = PS_RUNNING;
                  move   = 1'b1;
                  reason = RSN_GATES_PASS;
                end
              end
              PS_RUNNING: begin
                if (!gates_pass) begin
                  ps_d   = PS_ARMED;
                  move   = 1'b1;
                  reason = RSN_STALL;
                end
              end
              default: ;
            endcase
          end
        end
        KIND_GATE_MODE: begin
          if (a_gm_q != gm_q) begin
            ps_d   = PS_PRIME;
            gm_d   = a_gm_q;
            move   = 1'b1;
            reason = RSN_MODE;
          end
        end
        default: ;
      endcase
    end
    if (move) entry_d = a_time_q;
  end

  // Gate refreshes and the coil hysteresis.
  always_comb begin
    rpm_good_d  = rpm_good_q;
    rpm_seen_d  = rpm_seen_q;
    coil_good_d = coil_good_q;
    coil_seen_d = coil_seen_q;
    coil_on_d   = coil_on_q;
    last_rep_d  = last_rep_q;
    ign         = 1'b0;
    if (process && a_kind_q == KIND_RPM && a_rpm_q >= rpm_thr_q) begin
      rpm_good_d = a_time_q;
      rpm_seen_d = 1'b1;
    end
    if (process && a_kind_q == KIND_COIL) begin
      if (coil_on_q) begin
        coil_on_d = !(a_cv_q < coil_off_q);
      end else begin
        coil_on_d = a_cv_q >= coil_on_lvl_q;
      end
      if (coil_on_d) begin
        coil_good_d = a_time_q;
        coil_seen_d = 1'b1;
      end
      if (coil_on_d != coil_on_q || dt_rep >= {16'd0, heartbeat_q}) begin
        ign        = 1'b1;
        last_rep_d = a_time_q;
      end
    end
  end

  // Record for the back end.
  always_comb begin
    q_rec_o = '0;
    q_wr_o  = move || ign;
    if (ign) begin
      q_rec_o.rtype      = REC_IGNITION;
      q_rec_o.coil_level = a_cv_q;
      q_rec_o.coil_is_on = coil_on_d;
    end else begin
      q_rec_o.rtype      = (reason == RSN_STALL) ? REC_STALL : REC_ANNOUNCE;
      q_rec_o.relay_mask = 8'd1 << relay_idx_q;
      q_rec_o.relay_on   = ps_d != PS_ARMED;
      q_rec_o.pump_state = ps_d;
      q_rec_o.gate_mode  = gm_d;
      q_rec_o.reason     = reason;
      q_rec_o.gates_ok   = {coil_fresh, rpm_fresh};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q        <= PS_PRIME;
      entry_q     <= '0;
      gm_q        <= GATE_MODE_RST;
      rpm_good_q  <= '0;
      coil_good_q <= '0;
      last_rep_q  <= '0;
      rpm_seen_q  <= 1'b0;
      coil_seen_q <= 1'b0;
      coil_on_q   <= 1'b0;
    end else begin
      ps_q        <= ps_d;
      entry_q     <= entry_d;
      gm_q        <= gm_d;
      rpm_good_q  <= rpm_good_d;
      coil_good_q <= coil_good_d;
      last_rep_q  <= last_rep_d;
      rpm_seen_q  <= rpm_seen_d;
      coil_seen_q <= coil_seen_d;
      coil_on_q   <= coil_on_d;
    end
  end

endmodule

// ----- rtl/core/fpgs_queue.sv -----
// Short record queue between the front and back ends.
module fpgs_queue import fpgs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  rec_t  wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output rec_t  rd_data_o,
  output logic  rd_valid_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  rec_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o     = count_q == (PtrW+1)'(QDepth);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) count_d = count_q + 1'b1;
    if (do_rd && !do_wr) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ----- rtl/core/fpgs_back.sv -----
// Back end: expands queued records into result beats behind an output register.
module fpgs_back import fpgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  input  rec_t               rec_i,
  output logic               rec_rd_o,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic               last_o,
  output logic [7:0]         relay_mask_o,
  output logic               relay_on_o,
  output logic [1:0]         pump_state_o,
  output logic [2:0]         gate_mode_out_o,
  output logic [1:0]         reason_o,
  output logic [1:0]         gates_ok_o,
  output logic [LevelW-1:0]  coil_level_o,
  output logic               coil_is_on_o
);

  logic              out_valid_q, out_valid_d;
  logic [1:0]        beat_q, beat_d;
  logic              load, beat_last;
  res_kind_e         b_kind;
  logic [7:0]        b_mask;
  logic              b_relay_on;
  logic [1:0]        b_ps, b_reason, b_gates;
  logic [2:0]        b_gm;
  logic [LevelW-1:0] b_cv;
  logic              b_on;
  logic [1:0]        kind_q;
  logic              last_q, relay_on_q, coil_is_on_q;
  logic [7:0]        relay_mask_q;
  logic [1:0]        ps_q, reason_q, gates_q;
  logic [2:0]        gm_q;
  logic [LevelW-1:0] cv_q;

  assign empty = !out_valid_q;
  assign load  = rec_valid_i && (!out_valid_q || pop);

  // Beat selection from the head record and the beat number within it.
  always_comb begin
    b_kind     = RES_RELAY;
    b_mask     = '0;
    b_relay_on = 1'b0;
    b_ps       = '0;
    b_gm       = '0;
    b_reason   = '0;
    b_gates    = '0;
    b_cv       = '0;
    b_on       = 1'b0;
    beat_last  = 1'b0;
    case (rec_i.rtype)
      REC_IGNITION: begin
        b_kind    = RES_IGNITION;
        b_cv      = rec_i.coil_level;
        b_on      = rec_i.coil_is_on;
        beat_last = 1'b1;
      end
      REC_ANNOUNCE, REC_STALL: begin
        case (beat_q)
          2'd0: begin
            b_kind     = RES_RELAY;
            b_mask     = rec_i.relay_mask;
            b_relay_on = rec_i.relay_on;
          end
          2'd1: begin
            b_kind    = RES_STATE;
            b_ps      = rec_i.pump_state;
            b_gm      = rec_i.gate_mode;
            b_reason  = rec_i.reason;
            b_gates   = rec_i.gates_ok;
            beat_last = rec_i.rtype == REC_ANNOUNCE;
          end
          default: begin
            b_kind    = RES_STALL;
            beat_last = 1'b1;
          end
        endcase
      end
      default: beat_last = 1'b1;
    endcase
  end

  assign rec_rd_o = load && beat_last;

  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      beat_d      = beat_last ? 2'd0 : beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q       <= b_kind;
      last_q       <= beat_last;
      relay_mask_q <= b_mask;
      relay_on_q   <= b_relay_on;
      ps_q         <= b_ps;
      gm_q         <= b_gm;
      reason_q     <= b_reason;
      gates_q      <= b_gates;
      cv_q         <= b_cv;
      coil_is_on_q <= b_on;
    end
  end

  assign kind_o          = kind_q;
  assign last_o          = last_q;
  assign relay_mask_o    = relay_mask_q;
  assign relay_on_o      = relay_on_q;
  assign pump_state_o    = ps_q;
  assign gate_mode_out_o = gm_q;
  assign reason_o        = reason_q;
  assign gates_ok_o      = gates_q;
  assign coil_level_o    = cv_q;
  assign coil_is_on_o    = coil_is_on_q;

endmodule

// ----- rtl/core/fuel_pump_gate_safety_fsm.sv -----
// Top level of the fuel pump gate safety sequencer.
// An accepted item is scaled in the cycle it is taken; once the queue has room it updates
// the sequencer state and queues its record, and the back end then loads its first beat into
// the output register. A new item can be taken every cycle while the four-record queue has
// room. Results leave one beat a cycle while pop is high.
// Reset clears the sequencer to PRIME with both gates enabled and loads default configuration.
module fuel_pump_gate_safety_fsm import fpgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode_i,
  input  logic [TimeW-1:0]    time_ms_i,
  input  logic [15:0]         rpm_i,
  input  logic [LevelW-1:0]   coil_raw_i,
  input  logic [7:0]          new_gate_mode_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind_o,
  output logic                last_o,
  output logic [7:0]          relay_mask_o,
  output logic                relay_on_o,
  output logic [1:0]          pump_state_o,
  output logic [2:0]          gate_mode_out_o,
  output logic [1:0]          reason_o,
  output logic [1:0]          gates_ok_o,
  output logic [LevelW-1:0]   coil_level_o,
  output logic                coil_is_on_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  logic q_wr, q_full, q_rd, q_valid;
  rec_t q_wr_rec, q_rd_rec;

  fpgs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .mode_i          (mode_i),
    .time_ms_i       (time_ms_i),
    .rpm_i           (rpm_i),
    .coil_raw_i      (coil_raw_i),
    .new_gate_mode_i (new_gate_mode_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .q_wr_o          (q_wr),
    .q_rec_o         (q_wr_rec)
  );

  fpgs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_data_i  (q_wr_rec),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .rd_data_o  (q_rd_rec),
    .rd_valid_o (q_valid)
  );

  fpgs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (q_valid),
    .rec_i           (q_rd_rec),
    .rec_rd_o        (q_rd),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .last_o          (last_o),
    .relay_mask_o    (relay_mask_o),
    .relay_on_o      (relay_on_o),
    .pump_state_o    (pump_state_o),
    .gate_mode_out_o (gate_mode_out_o),
    .reason_o        (reason_o),
    .gates_ok_o      (gates_ok_o),
    .coil_level_o    (coil_level_o),
    .coil_is_on_o    (coil_is_on_o)
  );

endmodule

// ----- verif/fuel_pump_gate_safety_fsm_tb.sv -----
// Self-checking testbench for the fuel pump gate safety sequencer.
`timescale 1ns / 1ps

module fuel_pump_gate_safety_fsm_tb;
  import fpgs_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned IdlePct       = 13;
  localparam int unsigned NumRegs       = 8;

  typedef struct packed {
    res_kind_e         kind;
    logic              last;
    logic [7:0]        relay_mask;
    logic              relay_on;
    logic [1:0]        pump_state;
    logic [2:0]        gate_mode;
    logic [1:0]        reason;
    logic [1:0]        gates_ok;
    logic [LevelW-1:0] coil_level;
    logic              coil_is_on;
  } beat_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               push            = 1'b0;
  logic               full;
  logic [1:0]         mode_i          = '0;
  logic [TimeW-1:0]   time_ms_i       = '0;
  logic [15:0]        rpm_i           = '0;
  logic [LevelW-1:0]  coil_raw_i      = '0;
  logic [7:0]         new_gate_mode_i = '0;
  logic               empty;
  logic               pop             = 1'b0;
  logic [1:0]         kind_o;
  logic               last_o;
  logic [7:0]         relay_mask_o;
  logic               relay_on_o;
  logic [1:0]         pump_state_o;
  logic [2:0]         gate_mode_out_o;
  logic [1:0]         reason_o;
  logic [1:0]         gates_ok_o;
  logic [LevelW-1:0]  coil_level_o;
  logic               coil_is_on_o;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i       = '0;
  logic [CfgW-1:0]    cfg_data_i      = '0;

  fuel_pump_gate_safety_fsm dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .time_ms_i      (time_ms_i),
    .rpm_i          (rpm_i),
    .coil_raw_i     (coil_raw_i),
    .new_gate_mode_i(new_gate_mode_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .last_o         (last_o),
    .relay_mask_o   (relay_mask_o),
    .relay_on_o     (relay_on_o),
    .pump_state_o   (pump_state_o),
    .gate_mode_out_o(gate_mode_out_o),
    .reason_o       (reason_o),
    .gates_ok_o     (gates_ok_o),
    .coil_level_o   (coil_level_o),
    .coil_is_on_o   (coil_is_on_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register file as written, and as the block should see it after masking.
  logic [15:0] cfg_next   [NumRegs];
  logic [15:0] cfg_shadow [NumRegs];

  // Sequencer state mirrored from the block's behaviour.
  pump_state_e  pump_st        = PS_PRIME;
  logic [31:0]  entry_ms       = '0;
  logic [2:0]   gate_mode      = GATE_MODE_RST;
  logic [31:0]  rpm_good_ms    = '0;
  logic [31:0]  coil_good_ms   = '0;
  logic [31:0]  last_report_ms = '0;
  logic         rpm_seen       = 1'b0;
  logic         coil_seen      = 1'b0;
  logic         coil_on        = 1'b0;

  beat_t        awaited_beats[$];
  int unsigned  error_count   = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  push_idle_pct = IdlePct;
  int unsigned  pop_idle_pct  = IdlePct;
  logic [31:0]  clock_ms      = '0;

  initial begin
    cfg_shadow[CFG_PRIME_TIME] = PRIME_TIME_RST;
    cfg_shadow[CFG_STALL_TIME] = STALL_TIME_RST;
    cfg_shadow[CFG_RPM_THR]    = RPM_THR_RST;
    cfg_shadow[CFG_COIL_ON]    = 16'(COIL_ON_RST);
    cfg_shadow[CFG_COIL_OFF]   = 16'(COIL_OFF_RST);
    cfg_shadow[CFG_HEARTBEAT]  = HEARTBEAT_RST;
    cfg_shadow[CFG_COIL_GAIN]  = COIL_GAIN_RST;
    cfg_shadow[CFG_RELAY_IDX]  = 16'(RELAY_IDX_RST);
    cfg_next = cfg_shadow;
  end

  function automatic logic rpm_fresh(logic [31:0] now);
    logic [31:0] age;
    age = now - rpm_good_ms;
    return rpm_seen && (age < {16'd0, cfg_shadow[CFG_STALL_TIME]});
  endfunction

  function automatic logic coil_fresh(logic [31:0] now);
    logic [31:0] age;
    age = now - coil_good_ms;
    return coil_seen && (age < {16'd0, cfg_shadow[CFG_STALL_TIME]});
  endfunction

  function automatic logic gates_pass(logic [31:0] now);
    logic ok;
    ok = 1'b1;
    if (gate_mode[0]) ok = ok && rpm_fresh(now);
    if (gate_mode[1]) ok = ok && coil_fresh(now);
    return ok;
  endfunction

  function automatic beat_t relay_beat();
    beat_t b;
    b = '0;
    b.kind       = RES_RELAY;
    b.relay_mask = 8'b1 << cfg_shadow[CFG_RELAY_IDX][2:0];
    b.relay_on   = (pump_st == PS_ARMED) ? 1'b0 : 1'b1;
    return b;
  endfunction

  function automatic beat_t state_beat(logic [31:0] now, reason_e why);
    beat_t b;
    b = '0;
    b.kind       = RES_STATE;
    b.pump_state = pump_st;
    b.gate_mode  = gate_mode;
    b.reason     = why;
    b.gates_ok   = {coil_fresh(now), rpm_fresh(now)};
    return b;
  endfunction

  // Works out the beats that one accepted item causes and queues them.
  task automatic predict_sequencer(item_kind_e kind, logic [31:0] now, logic [15:0] rpm,
                                   logic [11:0] raw, logic [7:0] gm);
    beat_t       outs [3];
    int          n;
    logic [31:0] age;
    logic [27:0] prod;
    logic [11:0] cv;
    logic        was_on;
    n = 0;
    for (int i = 0; i < 3; i++) outs[i] = '0;
    case (kind)
      KIND_TICK: begin
        if (gate_mode != GATE_MODE_OFF) begin
          age = now - entry_ms;
          case (pump_st)
            PS_PRIME: begin
              if (age >= {16'd0, cfg_shadow[CFG_PRIME_TIME]}) begin
                pump_st  = PS_ARMED;
                entry_ms = now;
                outs[0]  = relay_beat();
                outs[1]  = state_beat(now, RSN_PRIME_DONE);
                n = 2;
              end
            end
            PS_ARMED: begin
              if (gates_pass(now)) begin
                pump_st  = PS_RUNNING;
                entry_ms = now;
                outs[0]  = relay_beat();
                outs[1]  = state_beat(now, RSN_GATES_PASS);
                n = 2;
              end
            end
            PS_RUNNING: begin
              if (!gates_pass(now)) begin
                pump_st      = PS_ARMED;
                entry_ms     = now;
                outs[0]      = relay_beat();
                outs[1]      = state_beat(now, RSN_STALL);
                outs[2].kind = RES_STALL;
                n = 3;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_RPM: begin
        if (rpm >= cfg_shadow[CFG_RPM_THR]) begin
          rpm_good_ms = now;
          rpm_seen    = 1'b1;
        end
      end
      KIND_COIL: begin
        prod   = 28'(raw) * 28'(cfg_shadow[CFG_COIL_GAIN]);
        cv     = prod[27:16];
        was_on = coil_on;
        if (coil_on) begin
          if (cv < cfg_shadow[CFG_COIL_OFF][11:0]) coil_on = 1'b0;
        end else if (cv >= cfg_shadow[CFG_COIL_ON][11:0]) begin
          coil_on = 1'b1;
        end
        if (coil_on) begin
          coil_good_ms = now;
          coil_seen    = 1'b1;
        end
        age = now - last_report_ms;
        if (was_on != coil_on || age >= {16'd0, cfg_shadow[CFG_HEARTBEAT]}) begin
          outs[0].kind       = RES_IGNITION;
          outs[0].coil_level = cv;
          outs[0].coil_is_on = coil_on;
          last_report_ms     = now;
          n = 1;
        end
      end
      default: begin
        if (gm[2:0] != gate_mode) begin
          gate_mode = gm[2:0];
          pump_st   = PS_PRIME;
          entry_ms  = now;
          outs[0]   = relay_beat();
          outs[1]   = state_beat(now, RSN_MODE);
          n = 2;
        end
      end
    endcase
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_beats.push_back(outs[i]);
  endtask

  // Fields that an item's kind does not use still get random values.
  task automatic send_item(item_kind_e kind, logic [31:0] t, logic [15:0] arg);
    logic [15:0] rpm_v;
    logic [11:0] raw_v;
    logic [7:0]  gm_v;
    rpm_v = (kind == KIND_RPM) ? arg : 16'($urandom);
    raw_v = (kind == KIND_COIL) ? arg[11:0] : 12'($urandom);
    gm_v  = (kind == KIND_GATE_MODE) ? arg[7:0] : 8'($urandom);
    push            <= 1'b1;
    mode_i          <= kind;
    time_ms_i       <= t;
    rpm_i           <= rpm_v;
    coil_raw_i      <= raw_v;
    new_gate_mode_i <= gm_v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_sequencer(kind, t, rpm_v, raw_v, gm_v);
    if ($urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < push_idle_pct);
    end
  endtask

  // Waits until every awaited beat has left, then lets the pipeline drain.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_config();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= cfg_next[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_shadow[CFG_PRIME_TIME] = cfg_next[CFG_PRIME_TIME];
    cfg_shadow[CFG_STALL_TIME] = cfg_next[CFG_STALL_TIME];
    cfg_shadow[CFG_RPM_THR]    = cfg_next[CFG_RPM_THR];
    cfg_shadow[CFG_COIL_ON]    = {4'd0, cfg_next[CFG_COIL_ON][11:0]};
    cfg_shadow[CFG_COIL_OFF]   = {4'd0, cfg_next[CFG_COIL_OFF][11:0]};
    cfg_shadow[CFG_HEARTBEAT]  = cfg_next[CFG_HEARTBEAT];
    cfg_shadow[CFG_COIL_GAIN]  = cfg_next[CFG_COIL_GAIN];
    cfg_shadow[CFG_RELAY_IDX]  = {13'd0, cfg_next[CFG_RELAY_IDX][2:0]};
  endtask

  // Reset configuration: prime, arm, run, stall, then the gate mode cases.
  task automatic test_default_sequence();
    send_item(KIND_TICK,      32'd2999,  16'd0);
    send_item(KIND_TICK,      32'd3000,  16'd0);
    send_item(KIND_TICK,      32'd3001,  16'd0);
    send_item(KIND_RPM,       32'd3002,  16'd199);
    send_item(KIND_RPM,       32'd3003,  16'd200);
    send_item(KIND_COIL,      32'd3004,  16'd0);
    send_item(KIND_COIL,      32'd3005,  16'd4095);
    send_item(KIND_TICK,      32'd3006,  16'd0);
    send_item(KIND_COIL,      32'd3500,  16'd1000);
    send_item(KIND_TICK,      32'd5004,  16'd0);
    send_item(KIND_GATE_MODE, 32'd5010,  16'h0003);
    send_item(KIND_GATE_MODE, 32'd5011,  16'h00F9);
    send_item(KIND_GATE_MODE, 32'd5012,  16'h00F8);
    send_item(KIND_TICK,      32'd9000,  16'd0);
    send_item(KIND_RPM,       32'd9001,  16'hFFFF);
    send_item(KIND_COIL,      32'd9002,  16'd4095);
    send_item(KIND_GATE_MODE, 32'd9003,  16'h0004);
    send_item(KIND_TICK,      32'd12003, 16'd0);
    send_item(KIND_TICK,      32'd12004, 16'd0);
    send_item(KIND_GATE_MODE, 32'd12005, 16'h00FF);
    send_item(KIND_TICK,      32'd12006, 16'd0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // Everything at its floor, the off level above the on level, widest gain, highest relay index.
    cfg_next[CFG_PRIME_TIME] = 16'd0;
    cfg_next[CFG_STALL_TIME] = 16'd0;
    cfg_next[CFG_RPM_THR]    = 16'd0;
    cfg_next[CFG_COIL_ON]    = 16'd0;
    cfg_next[CFG_COIL_OFF]   = 16'd4095;
    cfg_next[CFG_HEARTBEAT]  = 16'd0;
    cfg_next[CFG_COIL_GAIN]  = 16'hFFFF;
    cfg_next[CFG_RELAY_IDX]  = 16'd7;
    load_config();
    send_item(KIND_GATE_MODE, 32'd20000, 16'h0005);
    send_item(KIND_TICK,      32'd20000, 16'd0);
    send_item(KIND_TICK,      32'd20001, 16'd0);
    send_item(KIND_RPM,       32'd20002, 16'd0);
    send_item(KIND_TICK,      32'd20002, 16'd0);
    send_item(KIND_COIL,      32'd20003, 16'd4095);
    send_item(KIND_COIL,      32'd20004, 16'd4095);
    send_item(KIND_COIL,      32'd20005, 16'd0);
    send_item(KIND_GATE_MODE, 32'd20006, 16'h0004);
    send_item(KIND_TICK,      32'd20007, 16'd0);
    send_item(KIND_TICK,      32'd20008, 16'd0);
    send_item(KIND_TICK,      32'd20009, 16'd0);
    wait_idle();

    // Most fields at their ceiling, zero gain; upper data bits must be dropped by narrow registers.
    cfg_next[CFG_PRIME_TIME] = 16'hFFFF;
    cfg_next[CFG_STALL_TIME] = 16'hFFFF;
    cfg_next[CFG_RPM_THR]    = 16'hFFFF;
    cfg_next[CFG_COIL_ON]    = 16'hFFFF;
    cfg_next[CFG_COIL_OFF]   = 16'hF000;
    cfg_next[CFG_HEARTBEAT]  = 16'hFFFF;
    cfg_next[CFG_COIL_GAIN]  = 16'd0;
    cfg_next[CFG_RELAY_IDX]  = 16'hFFFB;
    load_config();
    send_item(KIND_GATE_MODE, 32'd30000, 16'h0003);
    send_item(KIND_COIL,      32'd30001, 16'd4095);
    send_item(KIND_RPM,       32'd30002, 16'd65534);
    send_item(KIND_RPM,       32'd30003, 16'd65535);
    send_item(KIND_TICK,      32'd95534, 16'd0);
    send_item(KIND_TICK,      32'd95535, 16'd0);
    send_item(KIND_TICK,      32'd95536, 16'd0);
    wait_idle();
  endtask

  // Freshness and prime timing across the 32-bit millisecond wrap.
  task automatic test_time_wrap();
    cfg_next[CFG_PRIME_TIME] = 16'd10;
    cfg_next[CFG_STALL_TIME] = STALL_TIME_RST;
    cfg_next[CFG_RPM_THR]    = RPM_THR_RST;
    cfg_next[CFG_COIL_ON]    = 16'(COIL_ON_RST);
    cfg_next[CFG_COIL_OFF]   = 16'(COIL_OFF_RST);
    cfg_next[CFG_HEARTBEAT]  = HEARTBEAT_RST;
    cfg_next[CFG_COIL_GAIN]  = COIL_GAIN_RST;
    cfg_next[CFG_RELAY_IDX]  = 16'd5;
    load_config();
    send_item(KIND_GATE_MODE, 32'hFFFF_FF00, 16'h0002);
    send_item(KIND_GATE_MODE, 32'hFFFF_FF01, 16'h0003);
    send_item(KIND_TICK,      32'h0000_0010, 16'd0);
    send_item(KIND_RPM,       32'hFFFF_FFF0, 16'd1000);
    send_item(KIND_COIL,      32'hFFFF_FFF8, 16'd4095);
    send_item(KIND_TICK,      32'h0000_0020, 16'd0);
    send_item(KIND_TICK,      32'h0000_07E0, 16'd0);
    send_item(KIND_RPM,       32'h0000_0800, 16'd1000);
    send_item(KIND_COIL,      32'h0000_0801, 16'd4095);
    send_item(KIND_TICK,      32'h0000_0802, 16'd0);
    wait_idle();
  endtask

  // Mostly time-ordered reports and ticks so the sequencer cycles through its
  // states; now and then a jump in time or an arbitrary gate mode.
  task automatic test_random_traffic(int unsigned items, bit no_idle);
    int unsigned on_lvl;
    int unsigned stall;
    int unsigned pick;
    logic [15:0] arg;
    item_kind_e  kind;
    on_lvl = $urandom_range(200, 2000);
    cfg_next[CFG_PRIME_TIME] = 16'($urandom_range(0, 400));
    cfg_next[CFG_STALL_TIME] = 16'($urandom_range(50, 1500));
    cfg_next[CFG_RPM_THR]    = 16'($urandom_range(0, 3000));
    cfg_next[CFG_COIL_ON]    = {4'($urandom), 12'(on_lvl)};
    if ($urandom_range(0, 9) == 0)
      cfg_next[CFG_COIL_OFF] = 16'($urandom_range(on_lvl, 4095));
    else
      cfg_next[CFG_COIL_OFF] = 16'($urandom_range(0, on_lvl));
    cfg_next[CFG_HEARTBEAT]  = 16'($urandom_range(0, 800));
    cfg_next[CFG_COIL_GAIN]  = 16'($urandom_range(16000, 65535));
    cfg_next[CFG_RELAY_IDX]  = 16'($urandom);
    load_config();
    stall = 32'(cfg_shadow[CFG_STALL_TIME]);
    if (no_idle) begin
      push_idle_pct = 0;
      pop_idle_pct  = 0;
    end
    for (int unsigned i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       clock_ms = $urandom;
      else if (pick < 13) clock_ms = clock_ms + $urandom_range(0, 3 * stall);
      else                clock_ms = clock_ms + $urandom_range(0, stall / 3 + 1);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        kind = KIND_TICK;
        arg  = 16'($urandom);
      end else if (pick < 60) begin
        kind = KIND_RPM;
        if ($urandom_range(0, 9) < 6) arg = 16'($urandom_range(cfg_shadow[CFG_RPM_THR], 65535));
        else                          arg = 16'($urandom);
      end else if (pick < 90) begin
        kind = KIND_COIL;
        arg  = 16'($urandom_range(0, 4095));
      end else begin
        kind = KIND_GATE_MODE;
        if ($urandom_range(0, 1) == 0) arg = 16'($urandom_range(0, 255));
        else                           arg = 16'($urandom_range(1, 3));
      end
      send_item(kind, clock_ms, arg);
    end
    wait_idle();
    push_idle_pct = IdlePct;
    pop_idle_pct  = IdlePct;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_side
    beat_t want;
    pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    if (rst_ni && pop && !empty) begin
      if (awaited_beats.size() == 0) begin
        $error("kind: expected no beat, actual %0d", kind_o);
        error_count++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("kind",          32'(want.kind),       32'(kind_o));
        check_field("last",          32'(want.last),       32'(last_o));
        check_field("relay_mask",    32'(want.relay_mask), 32'(relay_mask_o));
        check_field("relay_on",      32'(want.relay_on),   32'(relay_on_o));
        check_field("pump_state",    32'(want.pump_state), 32'(pump_state_o));
        check_field("gate_mode_out", 32'(want.gate_mode),  32'(gate_mode_out_o));
        check_field("reason",        32'(want.reason),     32'(reason_o));
        check_field("gates_ok",      32'(want.gates_ok),   32'(gates_ok_o));
        check_field("coil_level",    32'(want.coil_level), 32'(coil_level_o));
        check_field("coil_is_on",    32'(want.coil_is_on), 32'(coil_is_on_o));
      end
    end
  end

  // Any cycle that takes an item or pops a beat restarts the count.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_sequence();
    test_config_extremes();
    test_time_wrap();
    test_random_traffic(95, 1'b0);
    test_random_traffic(95, 1'b1);
    test_random_traffic(95, 1'b0);
    test_random_traffic(95, 1'b0);
    if (error_count == 0 && awaited_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
